FILE: design/bst_pkg.sv
// shared types and constants for the bounded set table
package bst_pkg;

	localparam int unsigned ValW   = 32;
	localparam int unsigned CntW   = 6;
	localparam int unsigned PosW   = 5;
	localparam logic [CntW-1:0] CapReset = 6'd32;

	typedef enum logic [1:0] {
		FUNC_LOOKUP = 2'd0,
		FUNC_ADD    = 2'd1,
		FUNC_REMOVE = 2'd2,
		FUNC_CLEAR  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_MISSING = 2'd1,
		ST_FULL    = 2'd2,
		ST_PRESENT = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_MOVE_RD,
		S_MOVE_WR,
		S_RESP
	} eng_state_t;

	typedef struct packed {
		logic [1:0]        func;
		logic signed [ValW-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic [1:0]      status;
		logic [PosW-1:0] position;
		logic [CntW-1:0] element_count;
		logic [CntW-1:0] free_slots;
	} out_item_t;

	typedef struct packed {
		logic      valid;
		out_item_t item;
	} res_t;

endpackage

FILE: design/bst_ram.sv
// element storage: one write port, one read port with registered read data
module bst_ram #(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned AW    = 5
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/bst_engine.sv
// sequencer: scans the stored elements, updates the count and writes back
module bst_engine import bst_pkg::*; #(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned AW    = 5
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  in_item_t        in_data,
	input  logic [CntW-1:0] cap_eff,
	output res_t            res,
	input  logic            res_ready
);

	eng_state_t state_q, state_d;

	logic [1:0]      func_q;
	logic [ValW-1:0] value_q;
	logic [CntW-1:0] count_q;
	logic [CntW-1:0] rd_idx_q;
	logic [CntW-1:0] where_q;
	logic [1:0]      status_q;
	logic [PosW-1:0] pos_q;
	logic            vld_s1;
	logic [CntW-1:0] idx_s1;

	logic          re, we;
	logic [AW-1:0] raddr, waddr;
	logic [31:0]   wdata, rdata;

	logic hit, miss, full, re_scan;

	bst_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// compare stage works on the data returned for the previous read
	assign hit     = vld_s1 && (rdata == value_q);
	assign miss    = !vld_s1 && (rd_idx_q >= count_q);
	assign full    = (count_q >= cap_eff);
	assign re_scan = (state_q == S_SCAN) && (rd_idx_q < count_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (in_data.func)
						FUNC_CLEAR: state_d = S_RESP;
						FUNC_ADD:   state_d = full ? S_RESP : S_SCAN;
						default:    state_d = S_SCAN;
					endcase
				end
			end
			S_SCAN: begin
				if (hit) begin
					state_d = (func_q == FUNC_REMOVE) ? S_MOVE_RD : S_RESP;
				end else if (miss) begin
					state_d = S_RESP;
				end
			end
			S_MOVE_RD: state_d = S_MOVE_WR;
			S_MOVE_WR: state_d = S_RESP;
			S_RESP: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		re       = 1'b0;
		raddr    = AW'(rd_idx_q);
		we       = 1'b0;
		waddr    = AW'(count_q);
		wdata    = value_q;
		case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_SCAN: begin
				re = re_scan;
				// append on an add that found no copy
				we = !hit && miss && (func_q == FUNC_ADD);
			end
			S_MOVE_RD: begin
				// count already decremented: this is the last entry
				re    = 1'b1;
				raddr = AW'(count_q);
			end
			S_MOVE_WR: begin
				we    = 1'b1;
				waddr = AW'(where_q);
				wdata = rdata;
			end
			default: ;
		endcase
	end

	always_comb begin
		res.valid              = (state_q == S_RESP);
		res.item.status        = status_q;
		res.item.position      = pos_q;
		res.item.element_count = count_q;
		res.item.free_slots    = (cap_eff > count_q) ? (cap_eff - count_q) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			rd_idx_q <= '0;
			vld_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					rd_idx_q <= '0;
					vld_s1   <= 1'b0;
					if (in_valid) begin
						if (in_data.func == FUNC_CLEAR) begin
							count_q <= '0;
						end
					end
				end
				S_SCAN: begin
					vld_s1 <= re_scan;
					if (re_scan) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (hit) begin
						if (func_q == FUNC_REMOVE) begin
							count_q <= count_q - 1'b1;
						end
					end else if (miss && func_q == FUNC_ADD) begin
						count_q <= count_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				func_q   <= in_data.func;
				value_q  <= in_data.value;
				pos_q    <= '0;
				status_q <= (in_data.func == FUNC_ADD && full) ? ST_FULL : ST_OK;
			end
			S_SCAN: begin
				idx_s1 <= rd_idx_q;
				if (hit) begin
					where_q <= idx_s1;
					if (func_q == FUNC_LOOKUP) begin
						pos_q <= PosW'(idx_s1);
					end
					status_q <= (func_q == FUNC_ADD) ? ST_PRESENT : ST_OK;
				end else if (miss) begin
					status_q <= (func_q == FUNC_ADD) ? ST_OK : ST_MISSING;
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: design/bounded_set_table_top.sv
// bounded set table: a scan reads the stored elements in order and stops at the first match or at the end
// a remove hit then moves the last entry into the freed slot
// clear and an add to a full set skip the scan; one request is handled at a time
// the rate is set by the single read port of the element memory, one entry per cycle
// a finished result sits in an output register while the next request is taken
// reset empties the set and sets the capacity limit to 32; memory contents are not cleared
module bounded_set_table_top import bst_pkg::*; #(
	parameter int unsigned DEPTH = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  in_item_t        in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output out_item_t       out_data,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [CntW-1:0] cfg_data
);

	localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CapMax = (DEPTH < 63) ? DEPTH : 63;

	logic [CntW-1:0] cap_q;
	logic [CntW-1:0] cap_eff;
	res_t            res;
	logic            res_ready;
	logic            out_valid_q;
	out_item_t       out_data_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CapReset;
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	// limit never exceeds the memory depth
	assign cap_eff = (cap_q > CntW'(CapMax)) ? CntW'(CapMax) : cap_q;

	bst_engine #(.DEPTH(DEPTH), .AW(AW)) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.cap_eff  (cap_eff),
		.res      (res),
		.res_ready(res_ready)
	);

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res.valid) begin
			out_data_q <= res.item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

FILE: dv/testbench.sv
// self-checking testbench for the bounded set table: queued requests, scoreboard, random stalls
module testbench;
	import bst_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH = 32;

	typedef struct packed {
		logic            is_cfg;
		in_item_t        req;
		logic [CntW-1:0] cap;
	} pending_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            in_valid = 1'b0;
	logic            in_ready;
	in_item_t        in_data = '0;
	logic            out_valid;
	logic            out_ready = 1'b0;
	out_item_t       out_data;
	logic            cfg_valid = 1'b0;
	logic            cfg_ready;
	logic [CntW-1:0] cfg_data = '0;

	pending_t        pending[$];
	out_item_t       expected_results[$];

	// set model
	logic [ValW-1:0] set_elems[DEPTH];
	int unsigned     set_held = 0;
	logic [CntW-1:0] cap_model = CapReset;

	int              errors = 0;
	int              results_seen = 0;
	int              send_gap = 0;
	int              stall_left = 0;
	int              hold_left = 0;
	logic            hold_done = 1'b0;
	logic            calm = 1'b0;
	int              cyc = 0;

	bounded_set_table_top #(.DEPTH(DEPTH)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	function automatic out_item_t apply_request(input in_item_t req);
		out_item_t   res;
		int unsigned lim;
		int unsigned hit;
		logic        found;
		lim = (cap_model > DEPTH) ? DEPTH : cap_model;
		res = '0;
		res.status = ST_OK;
		found = 1'b0;
		hit = 0;
		// first match wins
		for (int i = 0; i < set_held; i++) begin
			if (!found && set_elems[i] == req.value) begin
				found = 1'b1;
				hit = i;
			end
		end
		case (req.func)
			FUNC_LOOKUP: begin
				if (found)
					res.position = hit[PosW-1:0];
				else
					res.status = ST_MISSING;
			end
			FUNC_ADD: begin
				// full takes priority over already present
				if (set_held >= lim)
					res.status = ST_FULL;
				else if (found)
					res.status = ST_PRESENT;
				else begin
					set_elems[set_held] = req.value;
					set_held++;
				end
			end
			FUNC_REMOVE: begin
				if (!found)
					res.status = ST_MISSING;
				else begin
					set_held--;
					set_elems[hit] = set_elems[set_held];
				end
			end
			default: set_held = 0;
		endcase
		res.element_count = set_held[CntW-1:0];
		res.free_slots = (lim > set_held) ? CntW'(lim - set_held) : '0;
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 4);
		return $urandom_range(20, 80);
	endfunction

	task automatic queue_request(input func_t f, input logic [ValW-1:0] v);
		pending_t p;
		p = '0;
		p.req.func = f;
		p.req.value = v;
		pending.push_back(p);
	endtask

	task automatic queue_capacity(input logic [CntW-1:0] c);
		pending_t p;
		p = '0;
		p.is_cfg = 1'b1;
		p.cap = c;
		pending.push_back(p);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch on result %0d, %s: got %0d expected %0d",
			results_seen, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc % 300 == 0)
			calm <= ($urandom_range(0, 2) == 0);
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin : drive_requests
		logic in_busy;
		logic cfg_busy;
		if (!arst_n) begin
			in_valid <= 1'b0;
			cfg_valid <= 1'b0;
			send_gap = 0;
		end else begin
			in_busy = in_valid && !in_ready;
			cfg_busy = cfg_valid && !cfg_ready;
			if (in_valid && in_ready) begin
				expected_results.push_back(apply_request(in_data));
				send_gap = pick_gap();
			end
			if (cfg_valid && cfg_ready)
				cap_model = cfg_data;
			if (!in_busy && !cfg_busy) begin
				if (send_gap > 0 || pending.size() == 0) begin
					if (send_gap > 0)
						send_gap--;
					in_valid <= 1'b0;
					cfg_valid <= 1'b0;
				end else if (pending[0].is_cfg) begin
					in_valid <= 1'b0;
					// capacity changes only once every result is back
					if (expected_results.size() == 0 && !in_valid && !cfg_valid) begin
						cfg_data <= pending[0].cap;
						cfg_valid <= 1'b1;
						void'(pending.pop_front());
					end else
						cfg_valid <= 1'b0;
				end else begin
					in_data <= pending[0].req;
					in_valid <= 1'b1;
					cfg_valid <= 1'b0;
					void'(pending.pop_front());
				end
			end
		end
	end

	// receiver ready with random stalls and one long hold-off
	always @(posedge clk or negedge arst_n) begin : drive_ready
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
			hold_left = 0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (!hold_done && results_seen >= 400) begin
			hold_done = 1'b1;
			hold_left = 600;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left = pick_gap();
			out_ready <= 1'b0;
		end else
			out_ready <= 1'b1;
	end

	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_results.size() == 0)
				report_mismatch("unexpected result, status", out_data.status, 0);
			else begin
				want = expected_results.pop_front();
				if (out_data.status !== want.status)
					report_mismatch("status", out_data.status, want.status);
				if (out_data.position !== want.position)
					report_mismatch("position", out_data.position, want.position);
				if (out_data.element_count !== want.element_count)
					report_mismatch("element_count", out_data.element_count,
						want.element_count);
				if (out_data.free_slots !== want.free_slots)
					report_mismatch("free_slots", out_data.free_slots, want.free_slots);
			end
		end
	end

	initial begin : stimulus
		logic [CntW-1:0] phase_caps[10];
		logic [ValW-1:0] value_pool[40];
		logic [ValW-1:0] v;
		int              r;
		int              clear_pct;
		func_t           f;

		// directed: empty set, extremes, duplicates, remove with move of last entry
		queue_request(FUNC_LOOKUP, 32'd5);
		queue_request(FUNC_REMOVE, 32'd5);
		queue_request(FUNC_ADD, 32'h8000_0000);
		queue_request(FUNC_ADD, 32'h7fff_ffff);
		queue_request(FUNC_ADD, 32'hffff_ffff);
		queue_request(FUNC_ADD, 32'h0000_0000);
		queue_request(FUNC_ADD, 32'h7fff_ffff);
		queue_request(FUNC_LOOKUP, 32'h0000_0000);
		queue_request(FUNC_LOOKUP, 32'h8000_0000);
		queue_request(FUNC_REMOVE, 32'h8000_0000);
		queue_request(FUNC_LOOKUP, 32'h0000_0000);
		queue_request(FUNC_REMOVE, 32'd1234);
		queue_request(FUNC_CLEAR, 32'hffff_ffff);
		queue_request(FUNC_LOOKUP, 32'hffff_ffff);
		// small capacity: full, and full wins over already present
		queue_capacity(6'd2);
		queue_request(FUNC_ADD, 32'd11);
		queue_request(FUNC_ADD, 32'd22);
		queue_request(FUNC_ADD, 32'd33);
		queue_request(FUNC_ADD, 32'd11);
		// capacity below count: free slots saturate
		queue_capacity(6'd0);
		queue_request(FUNC_LOOKUP, 32'd22);
		queue_request(FUNC_ADD, 32'd44);
		queue_capacity(6'd1);
		queue_request(FUNC_REMOVE, 32'd11);
		queue_request(FUNC_ADD, 32'd55);
		// capacity above depth clamps to depth
		queue_capacity(6'd63);
		queue_request(FUNC_ADD, 32'd55);
		queue_request(FUNC_LOOKUP, 32'd55);
		queue_request(FUNC_CLEAR, 32'd0);

		phase_caps = '{6'd32, 6'd63, 6'd0, 6'd33, 6'd1, 6'd2, 6'd31, 6'd5,
			6'($urandom_range(0, 63)), 6'd32};
		for (int ph = 0; ph < 10; ph++) begin
			queue_capacity(phase_caps[ph]);
			value_pool[0] = 32'h0000_0000;
			value_pool[1] = 32'hffff_ffff;
			value_pool[2] = 32'h8000_0000;
			value_pool[3] = 32'h7fff_ffff;
			for (int k = 4; k < 40; k++)
				value_pool[k] = $urandom;
			clear_pct = (ph % 2 == 0) ? 1 : 4;
			for (int n = 0; n < 125; n++) begin
				r = $urandom_range(0, 99);
				if (r < clear_pct)
					f = FUNC_CLEAR;
				else if (r < 45)
					f = FUNC_ADD;
				else if (r < 72)
					f = FUNC_LOOKUP;
				else
					f = FUNC_REMOVE;
				if ($urandom_range(0, 99) < 85)
					v = value_pool[$urandom_range(0, 39)];
				else
					v = $urandom;
				queue_request(f, v);
			end
		end

		while (pending.size() != 0 || in_valid || cfg_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch("results still outstanding", 0, expected_results.size());
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin : watchdog
		#20_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
design/bst_pkg.sv
design/bst_ram.sv
design/bst_engine.sv
design/bounded_set_table_top.sv
dv/testbench.sv
